// File: design/dtpl_pkg.sv
// ----------------------------------------------------------------------------
// dtpl_pkg
// Types and constants shared by the DER TLV path locator.
// ----------------------------------------------------------------------------
`default_nettype none

package dtpl_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_PATH_ENTRIES   = 3'd0;
    localparam logic [2:0] REG_PATH_TAGS_LOW  = 3'd1;
    localparam logic [2:0] REG_PATH_TAGS_HIGH = 3'd2;
    localparam logic [2:0] REG_PATH_ENTER     = 3'd3;
    localparam logic [2:0] REG_STRIP_INTEGER  = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // result status codes
    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_WRONG_TAG = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_NO_PAD    = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    // walk phases
    localparam logic [2:0] PH_TAG  = 3'd0;
    localparam logic [2:0] PH_LEN0 = 3'd1;
    localparam logic [2:0] PH_LENX = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_PAD  = 3'd4;

    localparam logic [7:0] BITSTRING_TAG   = 8'h03;
    localparam logic [7:0] PAD_BYTE        = 8'h00;
    localparam logic [7:0] RESET_TAG_0     = 8'h30;
    localparam logic [6:0] LONG_COUNT_MAX  = 7'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] element_offset;
        logic [15:0] element_length;
    } t_out_item;

endpackage

`default_nettype wire

// File: design/der_tlv_path_locator.sv
// ----------------------------------------------------------------------------
// der_tlv_path_locator
// Streams a DER certificate byte by byte and locates the element at the end
// of a configured path of tag steps.
// ----------------------------------------------------------------------------
// Input channel: one certificate byte per beat, last_byte marks the final one.
// Output channel: at most one result beat per certificate (status, offset and
// length of the located element, or an error status with zero fields).
// Configuration: write enable, register index, 64-bit data; writes land at
// once and are meant for use between certificates.
// A byte's result is registered to o_out_valid in the cycle after the beat.
// Throughput: one byte per cycle when not stalled; every decision is a
// tag compare, a length shift or a count step on the current byte.
// A held result only stalls input when the output register is still full
// and the receiver is not taking it in the same cycle.
// Reset (synchronous, active low) restarts the walk, empties the output
// register and loads the default path: one skipped SEQUENCE step.
// ----------------------------------------------------------------------------
`default_nettype none

module der_tlv_path_locator
    import dtpl_pkg::*;
#(
    parameter int MAX_PATH       = 16,
    parameter int MAX_CERT_BYTES = 65536
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int SW = $clog2(MAX_PATH + 1);
    localparam int OW = $clog2(MAX_CERT_BYTES + 1);

    function automatic logic [15:0] sat16(input logic [16:0] v);
        return v[16] ? 16'hffff : v[15:0];
    endfunction

    // configuration
    logic [4:0]  r_path_entries;
    logic [63:0] r_tags_low;
    logic [63:0] r_tags_high;
    logic [15:0] r_enter_mask;
    logic        r_strip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_entries <= 5'd1;
            r_tags_low     <= {56'd0, RESET_TAG_0};
            r_tags_high    <= 64'd0;
            r_enter_mask   <= 16'd0;
            r_strip        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATH_ENTRIES:   r_path_entries <= i_cfg_wdata[4:0];
                REG_PATH_TAGS_LOW:  r_tags_low     <= i_cfg_wdata;
                REG_PATH_TAGS_HIGH: r_tags_high    <= i_cfg_wdata;
                REG_PATH_ENTER:     r_enter_mask   <= i_cfg_wdata[15:0];
                REG_STRIP_INTEGER:  r_strip        <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // walk state
    logic [SW-1:0] r_step,       n_step;
    logic [2:0]    r_phase,      n_phase;
    logic [1:0]    r_len_left,   n_len_left;
    logic [15:0]   r_accum,      n_accum;
    logic [15:0]   r_skip,       n_skip;
    logic [OW-1:0] r_offset,     n_offset;
    logic [OW-1:0] r_elem_start, n_elem_start;
    logic          r_decided,    n_decided;
    logic          r_lead_zero,  n_lead_zero;

    logic          r_out_valid;
    t_out_item     r_out;

    logic          in_fire;
    logic [7:0]    b;
    logic [4:0]    path_cnt;
    logic [4:0]    step5;
    logic [3:0]    step_idx;
    logic [7:0]    cur_tag;
    logic          cur_enter;
    logic          last_step;
    logic [OW-1:0] pos_next;

    logic          w_fire;
    logic [2:0]    w_status;
    logic [15:0]   w_off;
    logic [15:0]   w_len;
    logic          hdr;
    logic [15:0]   hdr_len;
    logic          strip_chk;
    logic          step_done;
    logic          res_fire;
    t_out_item     res;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign b          = i_in_data.data_byte;

    always_comb begin
        if (r_path_entries == 5'd0) begin
            path_cnt = 5'd1;
        end else if (r_path_entries > 5'(MAX_PATH)) begin
            path_cnt = 5'(MAX_PATH);
        end else begin
            path_cnt = r_path_entries;
        end
    end

    assign step5     = 5'(r_step);
    assign step_idx  = step5[3:0];
    assign cur_tag   = step_idx[3] ? r_tags_high[{step_idx[2:0], 3'b000} +: 8]
                                   : r_tags_low[{step_idx[2:0], 3'b000} +: 8];
    assign cur_enter = r_enter_mask[step_idx];
    assign last_step = (6'(step5) + 6'd1) >= 6'(path_cnt);
    assign pos_next  = r_offset + OW'(1);

    // one byte of the walk
    always_comb begin
        n_step       = r_step;
        n_phase      = r_phase;
        n_len_left   = r_len_left;
        n_accum      = r_accum;
        n_skip       = r_skip;
        n_elem_start = r_elem_start;
        n_lead_zero  = r_lead_zero;
        w_fire       = 1'b0;
        w_status     = ST_FOUND;
        w_off        = 16'd0;
        w_len        = 16'd0;
        hdr          = 1'b0;
        hdr_len      = 16'd0;
        strip_chk    = 1'b0;
        step_done    = 1'b0;

        case (r_phase)
            PH_TAG: begin
                n_elem_start = r_offset;
                if (b != cur_tag) begin
                    w_fire   = 1'b1;
                    w_status = ST_WRONG_TAG;
                end else begin
                    n_phase = PH_LEN0;
                end
            end
            PH_LEN0: begin
                if (b[7]) begin
                    if (b[6:0] > LONG_COUNT_MAX) begin
                        w_fire   = 1'b1;
                        w_status = ST_BAD_LEN;
                    end else if (b[6:0] == 7'd0) begin
                        hdr = 1'b1;
                    end else begin
                        n_len_left = b[1:0];
                        n_accum    = 16'd0;
                        n_phase    = PH_LENX;
                    end
                end else begin
                    hdr     = 1'b1;
                    hdr_len = {8'd0, b};
                end
            end
            PH_LENX: begin
                n_accum    = {r_accum[7:0], b};
                n_len_left = r_len_left - 2'd1;
                if (n_len_left == 2'd0) begin
                    hdr     = 1'b1;
                    hdr_len = n_accum;
                end
            end
            PH_SKIP: begin
                strip_chk = 1'b1;
                n_skip    = r_skip - 16'd1;
                if (n_skip == 16'd0) begin
                    step_done = 1'b1;
                end
            end
            PH_PAD: begin
                if (b != PAD_BYTE) begin
                    w_fire   = 1'b1;
                    w_status = ST_NO_PAD;
                end else begin
                    strip_chk = 1'b1;
                    step_done = 1'b1;
                end
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase

        // leading zero bytes of the stripped integer move its start forward
        if (strip_chk && r_strip && last_step && r_lead_zero) begin
            if (b == 8'd0) begin
                n_elem_start = pos_next;
            end else begin
                n_lead_zero = 1'b0;
            end
        end

        if (hdr) begin
            if (r_strip && last_step) begin
                n_elem_start = pos_next;
                n_lead_zero  = 1'b1;
            end
            if (cur_enter) begin
                if (cur_tag == BITSTRING_TAG) begin
                    n_phase = PH_PAD;
                end else begin
                    step_done = 1'b1;
                end
            end else if (hdr_len == 16'd0) begin
                step_done = 1'b1;
            end else begin
                n_skip  = hdr_len;
                n_phase = PH_SKIP;
            end
        end

        if (step_done) begin
            n_step  = r_step + SW'(1);
            n_phase = PH_TAG;
            if (last_step) begin
                w_fire   = 1'b1;
                w_status = ST_FOUND;
                w_off    = sat16(17'(n_elem_start));
                w_len    = (pos_next >= n_elem_start) ?
                           sat16(17'(pos_next - n_elem_start)) : 16'd0;
            end
        end
    end

    // beat-level control: bound check, truncation, restart on the last byte
    always_comb begin
        n_decided    = r_decided;
        n_offset     = r_offset;
        res_fire     = 1'b0;
        res.status   = ST_FOUND;
        res.element_offset = 16'd0;
        res.element_length = 16'd0;

        if (!r_decided) begin
            if (r_offset >= OW'(MAX_CERT_BYTES)) begin
                res_fire   = 1'b1;
                res.status = ST_TOO_LONG;
                n_decided  = 1'b1;
            end else if (w_fire) begin
                res_fire           = 1'b1;
                res.status         = w_status;
                res.element_offset = w_off;
                res.element_length = w_len;
                n_decided          = 1'b1;
            end else if (i_in_data.last_byte) begin
                res_fire   = 1'b1;
                res.status = ST_TRUNCATED;
                n_decided  = 1'b1;
            end
        end
        if (r_offset < OW'(MAX_CERT_BYTES)) begin
            n_offset = pos_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= '0;
            r_phase      <= PH_TAG;
            r_len_left   <= 2'd0;
            r_accum      <= 16'd0;
            r_skip       <= 16'd0;
            r_offset     <= '0;
            r_elem_start <= '0;
            r_decided    <= 1'b0;
            r_lead_zero  <= 1'b0;
        end else if (in_fire) begin
            if (i_in_data.last_byte) begin
                r_step       <= '0;
                r_phase      <= PH_TAG;
                r_len_left   <= 2'd0;
                r_accum      <= 16'd0;
                r_skip       <= 16'd0;
                r_offset     <= '0;
                r_elem_start <= '0;
                r_decided    <= 1'b0;
                r_lead_zero  <= 1'b0;
            end else begin
                r_offset  <= n_offset;
                r_decided <= n_decided;
                // walk state only moves while undecided and in bounds
                if (!r_decided && r_offset < OW'(MAX_CERT_BYTES)) begin
                    r_step       <= n_step;
                    r_phase      <= n_phase;
                    r_len_left   <= n_len_left;
                    r_accum      <= n_accum;
                    r_skip       <= n_skip;
                    r_elem_start <= n_elem_start;
                    r_lead_zero  <= n_lead_zero;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && res_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && res_fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: test/der_tlv_path_locator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// der_tlv_path_locator_tb
// Streams DER-like certificates through the path locator and checks every
// result beat against an in-bench walker that tracks tag, length, skip, pad
// and leading-zero state byte by byte. Covers directed corner cases, path
// extremes, output back-pressure and random walks.
// ----------------------------------------------------------------------------

module der_tlv_path_locator_tb;
    import dtpl_pkg::*;

    localparam int PATH_MAX      = 16;
    localparam int CERT_LIMIT    = 65536;
    localparam int ITEM_TARGET   = 1450;
    localparam int LONG_HOLD     = 300;
    localparam int STUCK_LIMIT   = 2000;
    localparam int WALKING       = -1;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_CONTEXT0 = 8'ha0;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] TAG_OCTETS   = 8'h04;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out_data;

    der_tlv_path_locator #(
        .MAX_PATH       (PATH_MAX),
        .MAX_CERT_BYTES (CERT_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // path settings as last written
    logic [4:0]  cfg_entries   = 5'd1;
    logic [63:0] cfg_tags_low  = {56'h0, RESET_TAG_0};
    logic [63:0] cfg_tags_high = '0;
    logic [15:0] cfg_enter     = '0;
    logic        cfg_strip     = 1'b0;

    // walker state
    logic [4:0]  step_idx   = '0;
    logic [2:0]  walk_ph    = PH_TAG;
    logic [1:0]  len_left   = '0;
    logic [15:0] len_acc    = '0;
    logic [15:0] skip_cnt   = '0;
    int unsigned pos_cnt    = 0;
    int unsigned elem_start = 0;
    bit          walk_done  = 1'b0;
    bit          lead_zero  = 1'b0;
    logic [15:0] found_off  = '0;
    logic [15:0] found_len  = '0;

    t_out_item   pending_results[$];
    logic [7:0]  cert_q[$];

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    bit          hold_req   = 1'b0;
    int unsigned mismatches = 0;
    int unsigned checked    = 0;
    int unsigned certs_sent = 0;
    int unsigned sent_bytes = 0;
    int unsigned walked_bytes  = 0;
    int unsigned path_settings = 0;
    int unsigned in_stalls  = 0;
    int unsigned held_cycles = 0;
    int unsigned stuck_cycles = 0;

    // ------------------------------------------------------------------------
    // walker
    // ------------------------------------------------------------------------
    function automatic int unsigned path_len();
        if (cfg_entries == 0) return 1;
        if (cfg_entries > PATH_MAX) return PATH_MAX;
        return cfg_entries;
    endfunction

    function automatic logic [7:0] step_tag(input logic [4:0] i);
        logic [127:0] all_tags;
        all_tags = {cfg_tags_high, cfg_tags_low};
        return all_tags[8 * i[3:0] +: 8];
    endfunction

    function automatic bit on_last();
        return step_idx + 1 >= path_len();
    endfunction

    function automatic logic [15:0] sat16(input int unsigned v);
        return (v > 32'hffff) ? 16'hffff : v[15:0];
    endfunction

    function automatic int step_finish(input int unsigned pos);
        step_idx = step_idx + 1'b1;
        walk_ph  = PH_TAG;
        if (step_idx >= path_len()) begin
            found_off = sat16(elem_start);
            found_len = sat16((pos + 1 >= elem_start) ? pos + 1 - elem_start : 0);
            return int'(ST_FOUND);
        end
        return WALKING;
    endfunction

    // strip mode: slide the start past leading zero content bytes
    function automatic void strip_zeros(input logic [7:0] b, input int unsigned pos);
        if (cfg_strip && on_last() && lead_zero) begin
            if (b == 8'h00) elem_start = pos + 1;
            else lead_zero = 1'b0;
        end
    endfunction

    function automatic int header_end(input logic [15:0] len, input int unsigned pos);
        if (cfg_strip && on_last()) begin
            elem_start = pos + 1;
            lead_zero  = 1'b1;
        end
        if (cfg_enter[step_idx[3:0]]) begin
            if (step_tag(step_idx) == BITSTRING_TAG) begin
                walk_ph = PH_PAD;
                return WALKING;
            end
            return step_finish(pos);
        end
        if (len == 0) return step_finish(pos);
        skip_cnt = len;
        walk_ph  = PH_SKIP;
        return WALKING;
    endfunction

    function automatic int walk_byte(input logic [7:0] b, input int unsigned pos);
        case (walk_ph)
            PH_TAG: begin
                elem_start = pos;
                if (b != step_tag(step_idx)) return int'(ST_WRONG_TAG);
                walk_ph = PH_LEN0;
                return WALKING;
            end
            PH_LEN0: begin
                // top bit set: long form, low bits give the count of length bytes
                if (b[7]) begin
                    if (b[6:0] > LONG_COUNT_MAX) return int'(ST_BAD_LEN);
                    if (b[6:0] == 7'd0) return header_end(16'd0, pos);
                    len_left = b[1:0];
                    len_acc  = '0;
                    walk_ph  = PH_LENX;
                    return WALKING;
                end
                return header_end({8'h00, b}, pos);
            end
            PH_LENX: begin
                len_acc  = {len_acc[7:0], b};
                len_left = len_left - 1'b1;
                if (len_left == 2'd0) return header_end(len_acc, pos);
                return WALKING;
            end
            PH_SKIP: begin
                strip_zeros(b, pos);
                skip_cnt = skip_cnt - 1'b1;
                if (skip_cnt == 16'd0) return step_finish(pos);
                return WALKING;
            end
            PH_PAD: begin
                if (b != PAD_BYTE) return int'(ST_NO_PAD);
                strip_zeros(b, pos);
                return step_finish(pos);
            end
            default: begin
                walk_ph = PH_TAG;
                return WALKING;
            end
        endcase
    endfunction

    function automatic void predict_byte(input t_in_item beat);
        int        verdict;
        t_out_item res;
        bit        hit;
        res = '0;
        hit = 1'b0;
        if (!walk_done) begin
            walked_bytes++;
            if (pos_cnt >= CERT_LIMIT) begin
                res.status = ST_TOO_LONG;
                hit = 1'b1;
            end else begin
                verdict = walk_byte(beat.data_byte, pos_cnt);
                if (verdict == int'(ST_FOUND)) begin
                    res.element_offset = found_off;
                    res.element_length = found_len;
                    hit = 1'b1;
                end else if (verdict > 0) begin
                    res.status = verdict[2:0];
                    hit = 1'b1;
                end else if (beat.last_byte) begin
                    res.status = ST_TRUNCATED;
                    hit = 1'b1;
                end
            end
        end
        if (pos_cnt < CERT_LIMIT) pos_cnt++;
        if (hit) begin
            walk_done = 1'b1;
            pending_results.push_back(res);
        end
        if (beat.last_byte) begin
            step_idx   = '0;
            walk_ph    = PH_TAG;
            len_left   = '0;
            len_acc    = '0;
            skip_cnt   = '0;
            pos_cnt    = 0;
            elem_start = 0;
            walk_done  = 1'b0;
            lead_zero  = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        t_in_item    beat;
        beat.data_byte = b;
        beat.last_byte = last;
        gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        predict_byte(beat);
        sent_bytes++;
    endtask

    task automatic send_cert();
        for (int k = 0; k < cert_q.size(); k++) send_byte(cert_q[k], k == cert_q.size() - 1);
        certs_sent++;
    endtask

    // lower valid and let every outstanding result come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic set_path(input logic [4:0] n, input logic [63:0] lo, input logic [63:0] hi,
                            input logic [15:0] mask, input logic strip);
        drain();
        cfg_beat(REG_PATH_ENTRIES, {59'h0, n});
        cfg_beat(REG_PATH_TAGS_LOW, lo);
        cfg_beat(REG_PATH_TAGS_HIGH, hi);
        cfg_beat(REG_PATH_ENTER, {48'h0, mask});
        cfg_beat(REG_STRIP_INTEGER, {63'h0, strip});
        i_cfg_we      <= 1'b0;
        cfg_entries   = n;
        cfg_tags_low  = lo;
        cfg_tags_high = hi;
        cfg_enter     = mask;
        cfg_strip     = strip;
        path_settings++;
    endtask

    // a certificate that follows the current path, mostly well formed
    function automatic void build_cert();
        int unsigned mode, len, form, cut, at;
        logic [7:0]  tag;
        logic        enter;
        cert_q.delete();
        mode = $urandom_range(0, 11);
        if (mode == 0) begin
            repeat ($urandom_range(1, 6)) cert_q.push_back(8'($urandom));
            return;
        end
        for (int s = 0; s < path_len(); s++) begin
            tag   = step_tag(5'(s));
            enter = cfg_enter[s];
            cert_q.push_back(tag);
            if (enter) len = $urandom_range(0, 65535);
            else if ($urandom_range(0, 15) == 0) len = $urandom_range(0, 300);
            else len = $urandom_range(0, 10);
            form = $urandom_range(0, 3);
            if (len == 0 && form == 3) begin
                cert_q.push_back(8'h80);
            end else if (len < 128 && form < 2) begin
                cert_q.push_back(8'(len));
            end else if (len < 256 && form < 3) begin
                cert_q.push_back(8'h81);
                cert_q.push_back(8'(len));
            end else begin
                cert_q.push_back(8'h82);
                cert_q.push_back(8'(len >> 8));
                cert_q.push_back(8'(len));
            end
            if (enter && tag == BITSTRING_TAG) begin
                cert_q.push_back(PAD_BYTE);
            end else if (!enter) begin
                repeat (len) cert_q.push_back(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom));
            end
        end
        repeat ($urandom_range(0, 2)) cert_q.push_back(8'($urandom));
        at = $urandom_range(0, cert_q.size() - 1);
        case (mode)
            1: cert_q[at] = cert_q[at] ^ (8'h01 << $urandom_range(0, 7));
            2: begin
                cut = $urandom_range(1, cert_q.size());
                while (cert_q.size() > cut) void'(cert_q.pop_back());
            end
            3: cert_q[at] = 8'h80 | 8'($urandom_range(3, 127));
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                stall = LONG_HOLD;
                hold_req = 1'b0;
                held_cycles += LONG_HOLD;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= 50)
            $display("%0t ns: mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            checked++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat, status", o_out_data.status, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.element_offset !== want.element_offset)
                    report_mismatch("element_offset", o_out_data.element_offset,
                                    want.element_offset);
                if (o_out_data.element_length !== want.element_length)
                    report_mismatch("element_length", o_out_data.element_length,
                                    want.element_length);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_ready) in_stalls++;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stuck_cycles <= 0;
        else stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     stuck_cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset path: one skipped SEQUENCE
    task automatic test_default_path();
        cert_q = {8'h30, 8'h03, 8'h01, 8'h02, 8'h03};
        send_cert();
        cert_q = {8'h30, 8'h80, 8'hff};             // zero length, trailing byte
        send_cert();
        cert_q = {8'h31};                           // wrong tag
        send_cert();
        cert_q = {8'h30, 8'h83};                    // three length bytes
        send_cert();
        cert_q = {8'h30, 8'h05, 8'h00};             // runs out early
        send_cert();
    endtask

    task automatic test_enter_and_strip();
        set_path(5'd3, {40'h0, TAG_INTEGER, BITSTRING_TAG, TAG_SEQUENCE}, '1, 16'h0003, 1'b1);
        cert_q = {8'h30, 8'h81, 8'h90, 8'h03, 8'h82, 8'h00, 8'h05, 8'h00,
                  8'h02, 8'h03, 8'h00, 8'h00, 8'h7f};
        send_cert();
        cert_q = {8'h30, 8'h00, 8'h03, 8'h01, 8'h05};   // bit string without pad
        send_cert();
        // zero count acts as one step; entered last step in strip mode
        set_path(5'd0, {56'h0, TAG_SEQUENCE}, '1, 16'hffff, 1'b1);
        cert_q = {8'h30, 8'h02, 8'h00, 8'h00};
        send_cert();
        set_path(5'd1, {56'h0, BITSTRING_TAG}, '0, 16'h0001, 1'b1);
        cert_q = {8'h03, 8'h01, 8'h00};
        send_cert();
    endtask

    task automatic test_path_extremes();
        set_path(5'd17, {TAG_SEQUENCE, TAG_CONTEXT0, TAG_INTEGER, BITSTRING_TAG,
                         TAG_OCTETS, TAG_SEQUENCE, TAG_INTEGER, TAG_SEQUENCE},
                 {8{TAG_SEQUENCE}}, 16'ha5c3, 1'b0);
        build_cert();
        send_cert();
        set_path(5'd31, '0, '0, 16'h0000, 1'b0);
        repeat (2) begin
            build_cert();
            send_cert();
        end
        set_path(5'd16, '1, '1, 16'hffff, 1'b1);
        build_cert();
        send_cert();
    endtask

    // receiver pauses while one-byte certificates keep coming
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        repeat (12) begin
            cert_q = {step_tag(5'd0) ^ 8'h01};
            send_cert();
        end
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_walks();
        int unsigned   sel;
        logic [4:0]    n;
        logic [127:0]  tags;
        logic [7:0]    t;
        logic [15:0]   mask;
        do begin
            sel = $urandom_range(0, 9);
            case (sel)
                0:       n = 5'd0;
                1:       n = 5'd16;
                2:       n = 5'($urandom_range(17, 31));
                default: n = 5'($urandom_range(1, 5));
            endcase
            for (int k = 0; k < PATH_MAX; k++) begin
                case ($urandom_range(0, 7))
                    0:       t = TAG_SEQUENCE;
                    1:       t = TAG_CONTEXT0;
                    2:       t = TAG_INTEGER;
                    3:       t = BITSTRING_TAG;
                    4:       t = TAG_OCTETS;
                    5:       t = 8'h00;
                    6:       t = 8'hff;
                    default: t = 8'($urandom);
                endcase
                tags[8 * k +: 8] = t;
            end
            if ($urandom_range(0, 4) == 0) mask = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0;
            else mask = 16'($urandom);
            set_path(n, tags[63:0], tags[127:64], mask, 1'($urandom_range(0, 1)));
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(4, 10)) begin
                build_cert();
                send_cert();
            end
        end while (sent_bytes < ITEM_TARGET);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_path();
        test_enter_and_strip();
        test_path_extremes();
        test_backpressure();
        test_random_walks();
        drain();
        $display("run covered %0d certificates, %0d bytes sent, %0d walked, %0d results",
                 certs_sent, sent_bytes, walked_bytes, checked);
        $display("%0d paths, input stalled %0d cycles, receiver paused %0d cycles in one hold",
                 path_settings, in_stalls, held_cycles);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
